/* sv/dfrm_pkg.sv */
package dfrm_pkg;

  localparam int unsigned FifoDepthDefault = 4;

  localparam logic [1:0] STATUS_DATA  = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_ERROR = 2'd2;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;
  localparam logic [3:0] OPCODE_TEXT = 4'h1;

  typedef struct packed {
    logic [7:0] data;
    logic [7:0] key;
    logic       last;
    logic [1:0] status;
  } cmd_t;

endpackage

/* sv/dfrm_fifo.sv */
module dfrm_fifo
  import dfrm_pkg::*;
#(
  parameter int unsigned Depth = FifoDepthDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  cmd_t wr_cmd_i,
  input  logic rd_i,
  output cmd_t rd_cmd_o,
  output logic full_o,
  output logic empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_wr, do_rd;

  assign full_o   = (count_q == FullCnt);
  assign empty_o  = (count_q == '0);
  assign do_wr    = wr_i && !full_o;
  assign do_rd    = rd_i && !empty_o;
  assign rd_cmd_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_d = count_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_cmd_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= FullCnt)
    else $error("Queue count exceeds its depth.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_wr && !do_rd) |=> (count_q == $past(count_q) + 1'b1))
    else $error("Queue count did not follow a lone write.");

endmodule

/* sv/dfrm_front.sv */
module dfrm_front
  import dfrm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] data_byte_i,
  output logic       wr_o,
  output cmd_t       cmd_o
);

  localparam logic [2:0] PH_HDR0 = 3'd0;
  localparam logic [2:0] PH_HDR1 = 3'd1;
  localparam logic [2:0] PH_LEN  = 3'd2;
  localparam logic [2:0] PH_KEY  = 3'd3;
  localparam logic [2:0] PH_DATA = 3'd4;

  logic [2:0]       phase_q, phase_d;
  logic [3:0]       left_q, left_d;
  logic             masked_q, masked_d;
  logic [3:0][7:0]  key_q, key_d;
  logic [1:0]       idx_q, idx_d;
  logic [63:0]      rem_q, rem_d;
  logic             finish;
  logic [3:0]       left_dec;
  logic [63:0]      rem_dec;

  assign left_dec = left_q - 4'd1;
  assign rem_dec  = rem_q - 64'd1;

  always_comb begin
    phase_d  = phase_q;
    left_d   = left_q;
    masked_d = masked_q;
    key_d    = key_q;
    idx_d    = idx_q;
    rem_d    = rem_q;
    finish   = 1'b0;
    wr_o     = 1'b0;
    cmd_o    = '{data: 8'd0, key: 8'd0, last: 1'b1, status: STATUS_ERROR};
    if (accept_i) begin
      unique case (phase_q)
        PH_HDR1: begin
          masked_d = data_byte_i[7];
          key_d    = '0;
          rem_d    = '0;
          if (data_byte_i[6:0] == LEN_EXT16) begin
            phase_d = PH_LEN;
            left_d  = 4'd2;
          end else if (data_byte_i[6:0] == LEN_EXT64) begin
            phase_d = PH_LEN;
            left_d  = 4'd8;
          end else begin
            rem_d  = {57'd0, data_byte_i[6:0]};
            finish = 1'b1;
          end
        end
        PH_LEN: begin
          rem_d  = {rem_q[55:0], data_byte_i};
          left_d = left_dec;
          finish = (left_dec == 4'd0);
        end
        PH_KEY: begin
          key_d  = {key_q[2:0], data_byte_i};
          left_d = left_dec;
          finish = (left_dec == 4'd0);
        end
        PH_DATA: begin
          wr_o  = 1'b1;
          cmd_o = '{data: data_byte_i, key: key_q[~idx_q], last: (rem_q == 64'd1),
                    status: STATUS_DATA};
          idx_d = idx_q + 2'd1;
          rem_d = rem_dec;
          if (rem_q == 64'd1) begin
            phase_d = PH_HDR0;
          end
        end
        default: begin
          if (data_byte_i[7] && data_byte_i[3:0] == OPCODE_TEXT) begin
            phase_d = PH_HDR1;
          end else begin
            phase_d = PH_HDR0;
            wr_o    = 1'b1;
          end
        end
      endcase
      if (finish) begin
        if (masked_d && phase_q != PH_KEY) begin
          phase_d = PH_KEY;
          left_d  = 4'd4;
        end else begin
          idx_d = 2'd0;
          if (rem_d == 64'd0) begin
            phase_d = PH_HDR0;
            wr_o    = 1'b1;
            cmd_o   = '{data: 8'd0, key: 8'd0, last: 1'b1, status: STATUS_EMPTY};
          end else begin
            phase_d = PH_DATA;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HDR0;
      left_q   <= '0;
      masked_q <= 1'b0;
      key_q    <= '0;
      idx_q    <= '0;
      rem_q    <= '0;
    end else begin
      phase_q  <= phase_d;
      left_q   <= left_d;
      masked_q <= masked_d;
      key_q    <= key_d;
      idx_q    <= idx_d;
      rem_q    <= rem_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) phase_q <= PH_DATA)
    else $error("Parser phase left its legal range.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DATA) |-> (rem_q != 64'd0))
    else $error("Payload phase entered with nothing left to receive.");

endmodule

/* sv/dfrm_back.sv */
module dfrm_back
  import dfrm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_empty_i,
  input  cmd_t       q_cmd_i,
  output logic       q_rd_o,
  input  logic       pop_i,
  output logic       empty_o,
  output logic [7:0] payload_byte_o,
  output logic       last_o,
  output logic [1:0] status_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       last_q;
  logic [1:0] status_q;

  assign q_rd_o  = !q_empty_i && (!valid_q || pop_i);
  assign valid_d = q_rd_o || (valid_q && !pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_rd_o) begin
      byte_q   <= q_cmd_i.data ^ q_cmd_i.key;
      last_q   <= q_cmd_i.last;
      status_q <= q_cmd_i.status;
    end
  end

  assign empty_o        = !valid_q;
  assign payload_byte_o = byte_q;
  assign last_o         = last_q;
  assign status_o       = status_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && status_q != STATUS_DATA) |-> (byte_q == 8'd0 && last_q))
    else $error("Status beat carries payload or lacks the last mark.");

endmodule

/* sv/websocket_frame_deframer_top.sv */
// WebSocket text-frame receiver with payload unmasking.
// Input channel: one stream byte per beat on data_byte_i, taken at a clock
// edge where push is high and full is low.
// Result channel: while empty is low, payload_byte_o, last_o and status_o
// hold the oldest result, which is taken at an edge where pop is high.
// Status 0 is an unmasked payload byte, status 1 reports a zero-length frame
// and status 2 reports a first header byte without FIN or with an opcode
// other than text; the last two always carry last_o high and a zero byte.
// Header, length and mask key bytes give no result, but for the status 1
// and 2 results. A result goes into the queue and then into the output
// register. The parser takes one byte per cycle while full is low and
// keeps a 64-bit length countdown. A result queue of FifoDepth entries
// sits between parser and output register. When the receiver stalls, the
// queue fills and full rises until pop drains it again.
// Reset puts the parser in front of a first header byte and empties the
// queue and the output register; the block is ready in the first cycle.
module websocket_frame_deframer_top
  import dfrm_pkg::*;
#(
  parameter int unsigned FifoDepth = FifoDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] payload_byte_o,
  output logic       last_o,
  output logic [1:0] status_o
);

  logic accept;
  logic front_wr;
  cmd_t front_cmd;
  cmd_t q_cmd;
  logic q_rd;
  logic q_empty;
  logic q_full;

  assign full   = q_full;
  assign accept = push && !q_full;

  dfrm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (data_byte_i),
    .wr_o        (front_wr),
    .cmd_o       (front_cmd)
  );

  dfrm_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (front_wr),
    .wr_cmd_i (front_cmd),
    .rd_i     (q_rd),
    .rd_cmd_o (q_cmd),
    .full_o   (q_full),
    .empty_o  (q_empty)
  );

  dfrm_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .q_cmd_i        (q_cmd),
    .q_rd_o         (q_rd),
    .pop_i          (pop),
    .empty_o        (empty),
    .payload_byte_o (payload_byte_o),
    .last_o         (last_o),
    .status_o       (status_o)
  );

endmodule
